// ===== rtl/core/netp_pkg.sv =====
`default_nettype none
package netp_pkg;

    localparam int MAX_EVENTS_DEF = 64;
    localparam int MAX_NEST_DEF   = 32;
    localparam int TIME_BITS_DEF  = 48;

    typedef enum logic [1:0] {
        FUNC_BEGIN = 2'd0,
        FUNC_END   = 2'd1,
        FUNC_RDEV  = 2'd2,
        FUNC_RDEDGE = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_IGNORED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        REG_ENABLED  = 2'd0,
        REG_EVENTS   = 2'd1,
        REG_INTERVAL = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CLEAR
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  event_id;
        logic [6:0]  caller_id;
        logic [47:0] timestamp;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] call_total;
        logic [47:0] inclusive_ticks;
        logic [47:0] self_ticks;
        logic [15:0] fault_total;
        logic [5:0]  open_depth;
        logic        report_due;
    } t_out;

endpackage
`default_nettype wire

// ===== rtl/core/netp_stack.sv =====
`default_nettype none
module netp_stack #(
    parameter int MAX_NEST  = netp_pkg::MAX_NEST_DEF,
    parameter int TIME_BITS = netp_pkg::TIME_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic [$clog2(MAX_NEST)-1:0] i_rd_addr,
    output logic [5:0]                       o_rd_id,
    output logic [TIME_BITS-1:0]             o_rd_start,
    output logic [TIME_BITS-1:0]             o_rd_child,
    input  wire logic                        i_wr_en,
    input  wire logic [$clog2(MAX_NEST)-1:0] i_wr_addr,
    input  wire logic [5:0]                  i_wr_id,
    input  wire logic [TIME_BITS-1:0]        i_wr_start,
    input  wire logic [TIME_BITS-1:0]        i_wr_child
);
    localparam int W = 6 + 2 * TIME_BITS;
    logic [W-1:0] mem [MAX_NEST];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= {i_wr_id, i_wr_start, i_wr_child};
        end
        r_q <= mem[i_rd_addr];
    end

    assign o_rd_id    = r_q[W-1 -: 6];
    assign o_rd_start = r_q[2*TIME_BITS-1 -: TIME_BITS];
    assign o_rd_child = r_q[TIME_BITS-1:0];
endmodule
`default_nettype wire

// ===== rtl/core/netp_cnt_mem.sv =====
`default_nettype none
module netp_cnt_mem #(
    parameter int DEPTH = 64,
    parameter int W     = 80
) (
    input  wire logic                     i_clk,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [W-1:0]                  o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [W-1:0]             i_wr_data
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/nested_event_timing_profiler_top.sv =====
`default_nettype none
// channel  | direction | signals
// item     | in        | i_start, o_busy, i_item
// result   | out       | o_res_valid, o_res
// config   | in        | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
// after reset a clearing pass writes every counter memory entry, one entry per
// cycle, busy high throughout
// for each item the memories are read at the accepting edge, checked and written back
// in the next cycle with busy high; the result beat follows in the cycle after,
// while the next item can already be accepted
// results are shown for one cycle by o_res_valid; the receiver cannot stall
module nested_event_timing_profiler_top #(
    parameter int MAX_EVENTS = netp_pkg::MAX_EVENTS_DEF,
    parameter int MAX_NEST   = netp_pkg::MAX_NEST_DEF,
    parameter int TIME_BITS  = netp_pkg::TIME_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    output logic                o_busy,
    input  wire netp_pkg::t_in  i_item,
    output logic                o_res_valid,
    output netp_pkg::t_out      o_res,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [47:0]    i_cfg_data
);
    import netp_pkg::*;

    localparam int NA   = $clog2(MAX_NEST);
    localparam int DB   = $clog2(MAX_NEST + 1);
    localparam int EA   = $clog2(MAX_EVENTS);
    localparam int EDGES = (MAX_EVENTS + 1) * MAX_EVENTS;
    localparam int GA   = $clog2(EDGES);
    localparam int EVW  = 32 + 2 * TIME_BITS;
    localparam int EGW  = 32 + TIME_BITS;
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

    t_state r_state, n_state;
    logic   r_en;
    logic [6:0]  r_evu;
    logic [47:0] r_intv;
    logic [DB-1:0] r_depth, n_depth;
    logic [15:0] r_fault, n_fault;
    logic [TIME_BITS-1:0] r_last, n_last;
    logic [GA-1:0] r_clr;
    t_in  r_it;
    logic r_valid_out;
    t_out r_res, n_res;

    // stack read addresses: top and parent
    logic [NA-1:0] top_a, par_a;
    logic [5:0] top_id, par_id;
    logic [TIME_BITS-1:0] top_st, top_ch, par_st, par_ch;
    logic st_we;
    logic [NA-1:0] st_wa;
    logic [5:0] st_wid;
    logic [TIME_BITS-1:0] st_ws, st_wc;
    logic [EVW-1:0] ev_rd, ev_wd;
    logic [EGW-1:0] eg_rd, eg_wd;
    logic ev_we, eg_we;
    logic [EA-1:0] ev_ra, ev_wa;
    logic [GA-1:0] eg_ra, eg_wa;

    // ids of open events kept in registers for the edge row lookup
    logic [5:0] r_ids [MAX_NEST];
    logic [5:0] par_row_id;
    logic [GA-1:0] r_eg_addr;

    always_comb begin
        top_a = NA'(r_depth - DB'(1));
        par_a = NA'(r_depth - DB'(2));
    end

    // two stack copies written together, read at the top and the entry below
    netp_stack #(.MAX_NEST(MAX_NEST), .TIME_BITS(TIME_BITS)) u_top (
        .i_clk, .i_rd_addr(top_a), .o_rd_id(top_id), .o_rd_start(top_st),
        .o_rd_child(top_ch), .i_wr_en(st_we), .i_wr_addr(st_wa),
        .i_wr_id(st_wid), .i_wr_start(st_ws), .i_wr_child(st_wc)
    );
    netp_stack #(.MAX_NEST(MAX_NEST), .TIME_BITS(TIME_BITS)) u_par (
        .i_clk, .i_rd_addr(par_a), .o_rd_id(par_id), .o_rd_start(par_st),
        .o_rd_child(par_ch), .i_wr_en(st_we), .i_wr_addr(st_wa),
        .i_wr_id(st_wid), .i_wr_start(st_ws), .i_wr_child(st_wc)
    );
    netp_cnt_mem #(.DEPTH(MAX_EVENTS), .W(EVW)) u_ev (
        .i_clk, .i_rd_addr(ev_ra), .o_rd_data(ev_rd),
        .i_wr_en(ev_we), .i_wr_addr(ev_wa), .i_wr_data(ev_wd)
    );
    netp_cnt_mem #(.DEPTH(EDGES), .W(EGW)) u_eg (
        .i_clk, .i_rd_addr(eg_ra), .o_rd_data(eg_rd),
        .i_wr_en(eg_we), .i_wr_addr(eg_wa), .i_wr_data(eg_wd)
    );

    always_comb begin
        par_row_id = (r_depth >= DB'(2)) ? r_ids[par_a] : 6'd0;
    end

    logic [GA-1:0] row_in;
    always_comb begin
        ev_ra  = EA'(i_item.event_id);
        row_in = (7'(i_item.caller_id) > 7'(MAX_EVENTS)) ? GA'(MAX_EVENTS)
                                                           : GA'(i_item.caller_id);
        eg_ra  = GA'(row_in * GA'(MAX_EVENTS) + GA'(i_item.event_id));
        if (i_item.func == FUNC_END) begin
            // parent of the item being closed
            eg_ra = GA'(((r_depth >= DB'(2)) ? GA'(par_row_id) : GA'(MAX_EVENTS))
                        * GA'(MAX_EVENTS) + GA'(i_item.event_id));
        end
    end

    // end-path arithmetic
    logic id_ok;
    logic [TIME_BITS-1:0] dt, selfc, ch_add;
    logic [31:0] ev_calls, eg_calls;
    logic [TIME_BITS-1:0] ev_inc, ev_self, eg_inc;
    logic [TIME_BITS:0] s1, s2, s3, s4;
    logic [47:0] ts;

    always_comb begin
        ts = 48'(r_it.timestamp[TIME_BITS-1:0]);
        dt = (r_it.timestamp[TIME_BITS-1:0] >= top_st)
             ? r_it.timestamp[TIME_BITS-1:0] - top_st : '0;
        selfc = (dt > top_ch) ? dt - top_ch : '0;
        ev_calls = ev_rd[EVW-1 -: 32];
        ev_inc   = ev_rd[2*TIME_BITS-1 -: TIME_BITS];
        ev_self  = ev_rd[TIME_BITS-1:0];
        eg_calls = eg_rd[EGW-1 -: 32];
        eg_inc   = eg_rd[TIME_BITS-1:0];
        s1 = {1'b0, ev_inc} + {1'b0, dt};
        s2 = {1'b0, ev_self} + {1'b0, selfc};
        s3 = {1'b0, eg_inc} + {1'b0, dt};
        s4 = {1'b0, par_ch} + {1'b0, dt};
        ch_add = s4[TIME_BITS] ? TMAX : s4[TIME_BITS-1:0];
    end

    always_comb begin
        n_state = r_state;
        n_depth = r_depth;
        n_fault = r_fault;
        n_last  = r_last;
        n_res   = '0;
        st_we = 1'b0; st_wa = '0; st_wid = '0; st_ws = '0; st_wc = '0;
        ev_we = 1'b0; ev_wa = EA'(r_it.event_id); ev_wd = '0;
        eg_we = 1'b0; eg_wa = r_clr; eg_wd = '0;
        id_ok  = r_en && (7'(r_it.event_id) < r_evu) && (7'(r_it.event_id) < 7'(MAX_EVENTS));
        unique case (r_state)
            S_CLEAR: begin
                eg_we = 1'b1;
                eg_wa = r_clr;
                ev_we = 1'b1;
                ev_wa = EA'(r_clr);
                if (r_clr == GA'(EDGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
                n_res.status = ST_DONE;
                if (!id_ok) begin
                    n_res.status = ST_IGNORED;
                end else begin
                    case (r_it.func)
                        FUNC_BEGIN: begin
                            if (r_depth >= DB'(MAX_NEST)) begin
                                n_res.status = ST_FULL;
                                if (r_fault != 16'hFFFF) n_fault = r_fault + 16'd1;
                            end else begin
                                st_we = 1'b1;
                                st_wa = NA'(r_depth);
                                st_wid = r_it.event_id;
                                st_ws = r_it.timestamp[TIME_BITS-1:0];
                                n_depth = r_depth + DB'(1);
                            end
                        end
                        FUNC_END: begin
                            if (r_depth == '0) begin
                                n_res.status = ST_EMPTY;
                                if (r_fault != 16'hFFFF) n_fault = r_fault + 16'd1;
                            end else if (top_id != r_it.event_id) begin
                                n_res.status = ST_MISMATCH;
                                if (r_fault != 16'hFFFF) n_fault = r_fault + 16'd1;
                            end else begin
                                n_depth = r_depth - DB'(1);
                                ev_we = 1'b1;
                                ev_wd = {(ev_calls == 32'hFFFFFFFF) ? ev_calls
                                                                     : ev_calls + 32'd1,
                                         s1[TIME_BITS] ? TMAX : s1[TIME_BITS-1:0],
                                         s2[TIME_BITS] ? TMAX : s2[TIME_BITS-1:0]};
                                eg_we = 1'b1;
                                eg_wa = r_eg_addr;
                                eg_wd = {(eg_calls == 32'hFFFFFFFF) ? eg_calls
                                                                     : eg_calls + 32'd1,
                                         s3[TIME_BITS] ? TMAX : s3[TIME_BITS-1:0]};
                                if (r_depth >= DB'(2)) begin
                                    st_we = 1'b1;
                                    st_wa = par_a;
                                    st_wid = par_id;
                                    st_ws = par_st;
                                    st_wc = ch_add;
                                end
                                if (r_depth == DB'(1) && r_intv != '0 &&
                                    ts >= 48'(r_last) && ts - 48'(r_last) >= r_intv) begin
                                    n_last = r_it.timestamp[TIME_BITS-1:0];
                                    n_res.report_due = 1'b1;
                                end
                            end
                        end
                        FUNC_RDEV: begin
                            n_res.call_total = ev_calls;
                            n_res.inclusive_ticks = 48'(ev_inc);
                            n_res.self_ticks = 48'(ev_self);
                        end
                        default: begin
                            if (r_it.caller_id > 7'(MAX_EVENTS)) begin
                                n_res.status = ST_IGNORED;
                            end else begin
                                n_res.call_total = eg_calls;
                                n_res.inclusive_ticks = 48'(eg_inc);
                            end
                        end
                    endcase
                end
                n_res.fault_total = n_fault;
                n_res.open_depth = 6'(n_depth);
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_en <= 1'b0;
            r_evu <= '0;
            r_intv <= '0;
            r_depth <= '0;
            r_fault <= '0;
            r_last <= '0;
            r_clr <= '0;
            r_valid_out <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_fault <= n_fault;
            r_last <= n_last;
            r_valid_out <= (r_state == S_READ);
            if (r_state == S_CLEAR) r_clr <= r_clr + GA'(1);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_ENABLED:  r_en <= i_cfg_data[0];
                    REG_EVENTS:   r_evu <= i_cfg_data[6:0];
                    REG_INTERVAL: r_intv <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_it <= i_item;
            r_eg_addr <= eg_ra;
        end
        if (r_state == S_READ) r_res <= n_res;
        if (st_we && r_state == S_READ && r_it.func == FUNC_BEGIN) begin
            r_ids[st_wa] <= st_wid;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_valid_out;
    assign o_res       = r_res;
endmodule
`default_nettype wire
